### rtl/hmpc_pkg.sv
`default_nettype none

package hmpc_pkg;

    // Fixed field widths
    localparam int HEIGHT_W   = 10;
    localparam int LEVEL_W    = 10;
    localparam int DIM_CFG_W  = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int DASH_W     = 5;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 32;
    localparam int IN_TDATA_W = 16;
    // Widest shade numerator: 1023 * 255 fits in 18 bits.
    localparam int NUM_W      = 18;
    localparam int QUEUE_DEPTH = 4;

    // Default parameter values
    localparam int DEF_MAX_HEIGHT = 1023;
    localparam int DEF_MAX_DIM    = 4096;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEA_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAND_MODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEA_LEVEL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT     = 3'd5;

    // Land shading modes
    localparam logic [1:0] LAND_HIGHEST = 2'd0;
    localparam logic [1:0] LAND_MAX     = 2'd1;
    localparam logic [1:0] LAND_FIXED   = 2'd2;
    localparam logic [1:0] LAND_INVALID = 2'd3;

    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 13'd4096;

    // Arithmetic constants
    localparam int DASH_PERIOD = 30;
    localparam int DASH_ON     = 10;
    localparam int SHADE_SPAN  = 155;
    localparam int SHADE_BASE  = 100;
    localparam int FULL_SCALE  = 255;

    // Colours
    localparam logic [CHAN_W-1:0] CH_FULL   = 8'd255;
    localparam logic [CHAN_W-1:0] CH_ZERO   = 8'd0;
    localparam logic [CHAN_W-1:0] DASH_R    = 8'd75;
    localparam logic [CHAN_W-1:0] DASH_G    = 8'd110;
    localparam logic [CHAN_W-1:0] DASH_B    = 8'd190;
    localparam logic [CHAN_W-1:0] SEA_R     = 8'd25;
    localparam logic [CHAN_W-1:0] SEA_G     = 8'd45;
    localparam logic [CHAN_W-1:0] SEA_B     = 8'd85;

    typedef enum logic [1:0] {
        KIND_GREEN,
        KIND_DASH,
        KIND_SEA,
        KIND_LAND
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              eof;
        logic              add_base;
        logic [NUM_W-1:0]  numer;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } t_back_state;

    function automatic int calc_span_w(input int max_height);
        int w;
        w = $clog2(max_height + 1);
        return (w > HEIGHT_W) ? w : HEIGHT_W;
    endfunction

    function automatic logic [PIXEL_W-1:0] pack_rgba(input logic [CHAN_W-1:0] r,
                                                     input logic [CHAN_W-1:0] g,
                                                     input logic [CHAN_W-1:0] b);
        return {r, g, b, CH_FULL};
    endfunction

endpackage

`default_nettype wire

### rtl/hmpc_fifo.sv
`default_nettype none

module hmpc_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hmpc_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output hmpc_pkg::t_job      o_job,
    output logic                o_empty
);
    import hmpc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

### rtl/hmpc_front.sv
`default_nettype none

module hmpc_front #(
    parameter int MAX_HEIGHT = hmpc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_DIM    = hmpc_pkg::DEF_MAX_DIM
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_cfg_we,
    input  wire logic [hmpc_pkg::CFG_IDX_W-1:0]               i_cfg_idx,
    input  wire logic [hmpc_pkg::CFG_DATA_W-1:0]              i_cfg_data,
    input  wire logic                                         i_valid,
    output logic                                              o_ready,
    input  wire logic [hmpc_pkg::HEIGHT_W-1:0]                i_height,
    input  wire logic                                         i_full,
    output logic                                              o_push,
    output hmpc_pkg::t_job                                    o_job,
    output logic [hmpc_pkg::calc_span_w(MAX_HEIGHT)-1:0]      o_span
);
    import hmpc_pkg::*;

    localparam int SPAN_W = calc_span_w(MAX_HEIGHT);
    localparam int DIM_W  = ($clog2(MAX_DIM + 1) > DIM_CFG_W) ? $clog2(MAX_DIM + 1) : DIM_CFG_W;
    localparam int COL_W  = $clog2(MAX_DIM);

    logic                  r_sea_mode;
    logic [1:0]            r_land_mode;
    logic [LEVEL_W-1:0]    r_sea_level;
    logic [LEVEL_W-1:0]    r_highest;
    logic [DIM_CFG_W-1:0]  r_map_w;
    logic [DIM_CFG_W-1:0]  r_map_h;
    logic [COL_W-1:0]      r_col;
    logic [COL_W-1:0]      r_row;
    logic [DASH_W-1:0]     r_dash;
    logic [SPAN_W-1:0]     r_span;

    logic [SPAN_W-1:0]     n_span;
    logic [SPAN_W-1:0]     top;
    logic [SPAN_W-1:0]     sea_ext;
    logic [DIM_W-1:0]      w_ext;
    logic [DIM_W-1:0]      h_ext;
    logic [DIM_W-1:0]      w_last;
    logic [DIM_W-1:0]      h_last;
    logic                  last_col;
    logic                  last_row;
    logic                  accept;
    logic                  fixed_mode;
    logic [HEIGHT_W-1:0]   diff;
    logic [HEIGHT_W-1:0]   mul_a;
    logic [CHAN_W-1:0]     mul_b;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sea_mode  <= 1'b0;
            r_land_mode <= LAND_FIXED;
            r_sea_level <= '0;
            r_highest   <= '0;
            r_map_w     <= DIM_RESET;
            r_map_h     <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEA_MODE:       r_sea_mode  <= i_cfg_data[0];
                CFG_LAND_MODE: begin
                    if (i_cfg_data[1:0] != LAND_INVALID) begin
                        r_land_mode <= i_cfg_data[1:0];
                    end
                end
                CFG_SEA_LEVEL:      r_sea_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_HIGHEST_HEIGHT: r_highest   <= i_cfg_data[LEVEL_W-1:0];
                CFG_MAP_WIDTH:      r_map_w     <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_MAP_HEIGHT:     r_map_h     <= i_cfg_data[DIM_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Divisor for the shade, held steady while configuration is unchanged.
    assign fixed_mode = (r_land_mode == LAND_FIXED);
    assign sea_ext    = SPAN_W'(r_sea_level);
    assign top        = (r_land_mode == LAND_HIGHEST) ? SPAN_W'(r_highest)
                                                      : SPAN_W'(MAX_HEIGHT);
    always_comb begin
        if (fixed_mode) begin
            n_span = SPAN_W'(MAX_HEIGHT);
        end else if (top > sea_ext) begin
            n_span = top - sea_ext;
        end else begin
            n_span = SPAN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_span <= n_span;
    end
    assign o_span = r_span;

    // Clamped dimensions and raster position
    always_comb begin
        w_ext = DIM_W'(r_map_w);
        h_ext = DIM_W'(r_map_h);
        if (w_ext == '0) begin
            w_ext = DIM_W'(1);
        end else if (w_ext > DIM_W'(MAX_DIM)) begin
            w_ext = DIM_W'(MAX_DIM);
        end
        if (h_ext == '0) begin
            h_ext = DIM_W'(1);
        end else if (h_ext > DIM_W'(MAX_DIM)) begin
            h_ext = DIM_W'(MAX_DIM);
        end
        w_last = w_ext - 1'b1;
        h_last = h_ext - 1'b1;
    end

    assign last_col = (DIM_W'(r_col) >= w_last);
    assign last_row = (DIM_W'(r_row) >= h_last);

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    // Numerator of the shade: one small multiply per item.
    assign diff  = (i_height > r_sea_level) ? i_height - r_sea_level : '0;
    assign mul_a = fixed_mode ? i_height : diff;
    assign mul_b = fixed_mode ? CHAN_W'(FULL_SCALE) : CHAN_W'(SHADE_SPAN);

    always_comb begin
        o_job.eof      = last_col && last_row;
        o_job.add_base = !fixed_mode;
        o_job.numer    = NUM_W'(mul_a) * NUM_W'(mul_b);
        if (r_col == '0 && (r_row == '0 || last_row)) begin
            o_job.kind = KIND_GREEN;
        end else if (r_col == '0 && r_dash < DASH_W'(DASH_ON)) begin
            o_job.kind = KIND_DASH;
        end else if (r_sea_mode && i_height <= r_sea_level) begin
            o_job.kind = KIND_SEA;
        end else begin
            o_job.kind = KIND_LAND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_dash <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                if (last_row) begin
                    r_row  <= '0;
                    r_dash <= '0;
                end else begin
                    r_row  <= r_row + 1'b1;
                    r_dash <= (r_dash >= DASH_W'(DASH_PERIOD - 1)) ? '0 : r_dash + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    a_dash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dash < DASH_W'(DASH_PERIOD))
        else $error("dash phase out of range");
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last_col && last_row |=> r_col == '0 && r_row == '0 && r_dash == '0)
        else $error("raster position not cleared after end of frame");
    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last_col |=> r_col == '0)
        else $error("column not cleared after last column");

endmodule

`default_nettype wire

### rtl/hmpc_back.sv
`default_nettype none

module hmpc_back #(
    parameter int MAX_HEIGHT = hmpc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_empty,
    input  wire hmpc_pkg::t_job                               i_job,
    output logic                                              o_pop,
    input  wire logic [hmpc_pkg::calc_span_w(MAX_HEIGHT)-1:0] i_span,
    output logic                                              o_valid,
    input  wire logic                                         i_ready,
    output logic [hmpc_pkg::PIXEL_W-1:0]                      o_pixel,
    output logic                                              o_last
);
    import hmpc_pkg::*;

    localparam int SPAN_W = calc_span_w(MAX_HEIGHT);
    localparam int CNT_W  = $clog2(NUM_W);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [SPAN_W-1:0]    r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic                 r_add_base;
    logic                 r_eof;
    logic                 r_valid;
    logic [PIXEL_W-1:0]   r_pixel;
    logic                 r_last;

    logic                 slot_free;
    logic                 load_out;
    logic                 start_div;
    logic [PIXEL_W-1:0]   n_pixel;
    logic                 n_last;
    logic [SPAN_W:0]      rem_sh;
    logic                 q_bit;
    logic [NUM_W:0]       shade_sum;
    logic [CHAN_W-1:0]    shade;

    assign slot_free = !r_valid || i_ready;

    // One restoring division step per cycle.
    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, i_span});

    assign shade_sum = (NUM_W + 1)'(r_quo) + (r_add_base ? (NUM_W + 1)'(SHADE_BASE) : '0);
    assign shade     = (shade_sum > (NUM_W + 1)'(FULL_SCALE)) ? CH_FULL : shade_sum[CHAN_W-1:0];

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        load_out  = 1'b0;
        start_div = 1'b0;
        n_pixel   = pack_rgba(shade, shade, shade);
        n_last    = r_eof;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty && slot_free) begin
                    o_pop  = 1'b1;
                    n_last = i_job.eof;
                    unique case (i_job.kind)
                        KIND_GREEN: begin
                            load_out = 1'b1;
                            n_pixel  = pack_rgba(CH_ZERO, CH_FULL, CH_ZERO);
                        end
                        KIND_DASH: begin
                            load_out = 1'b1;
                            n_pixel  = pack_rgba(DASH_R, DASH_G, DASH_B);
                        end
                        KIND_SEA: begin
                            load_out = 1'b1;
                            n_pixel  = pack_rgba(SEA_R, SEA_G, SEA_B);
                        end
                        KIND_LAND: begin
                            start_div = 1'b1;
                            n_state   = BK_DIV;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = BK_HOLD;
                end
            end
            BK_HOLD: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start_div) begin
                r_cnt <= '0;
            end else if (r_state == BK_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_div) begin
            r_rem      <= '0;
            r_quo      <= i_job.numer;
            r_add_base <= i_job.add_base;
            r_eof      <= i_job.eof;
        end else if (r_state == BK_DIV) begin
            r_rem <= q_bit ? SPAN_W'(rem_sh - {1'b0, i_span}) : rem_sh[SPAN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
        end
        if (load_out) begin
            r_pixel <= n_pixel;
            r_last  <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == BK_IDLE && !i_empty)
        else $error("queue popped outside idle state");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && r_valid |-> i_ready)
        else $error("pending result overwritten");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_DIV |-> r_cnt <= CNT_W'(NUM_W - 1))
        else $error("divider step count out of range");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_DIV && r_cnt == CNT_W'(NUM_W - 1) |=> r_state == BK_HOLD)
        else $error("divider did not finish after the last step");

endmodule

`default_nettype wire

### rtl/heightmap_pixel_colorizer.sv
// Channel    | Dir | Transaction                     | Payload
// -----------+-----+---------------------------------+-----------------------------------
// s_axis     | in  | one height sample, raster order | tdata[9:0] height, [15:10] zero
// m_axis     | out | one RGBA8888 pixel              | tdata[31:0] pixel, tlast end_of_frame
// i_cfg      | in  | one register write, no wait     | idx 0..5, data[12:0]
//
// Marker and sea pixels leave at one per cycle while the sink is ready. A
// land pixel holds the back end, which takes no new job meanwhile, while
// the bit-serial divider forms the grey shade, one quotient bit per cycle.
// Reset is synchronous and active low; it restores the register defaults and
// clears the raster position, the queue and the output stage.
// The front end keeps taking samples while the four-entry queue has room, so
// a stalled output or a busy divider only blocks input once the queue fills.
`default_nettype none

module heightmap_pixel_colorizer #(
    parameter int MAX_HEIGHT = hmpc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_DIM    = hmpc_pkg::DEF_MAX_DIM
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [hmpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [hmpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Height samples
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [hmpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [9:0] height
    // Pixels
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [hmpc_pkg::PIXEL_W-1:0]           m_axis_tdata,   // [31:0] pixel
    output logic                                   m_axis_tlast
);
    import hmpc_pkg::*;

    localparam int SPAN_W = calc_span_w(MAX_HEIGHT);

    // Front end to queue
    logic               push;
    logic               full;
    t_job               front_job;
    // Queue to back end
    logic               pop;
    logic               empty;
    t_job               back_job;
    // Shade divisor, derived from the configuration registers
    logic [SPAN_W-1:0]  span;

    // The front end owns the registers and the raster position. It sorts each
    // sample into a marker, a sea or a land pixel and forms the shade numerator.
    hmpc_front #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_DIM    (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_height   (s_axis_tdata[HEIGHT_W-1:0]),
        .i_full     (full),
        .o_push     (push),
        .o_job      (front_job),
        .o_span     (span)
    );

    // The short queue lets the front end run ahead while a division is busy.
    hmpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (back_job),
        .o_empty (empty)
    );

    // The back end colours each job, dividing for land pixels, and holds the
    // finished pixel in its output register until the sink takes it.
    hmpc_back #(
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (back_job),
        .o_pop   (pop),
        .i_span  (span),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pixel (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
